### rtl/core/pgng_pkg.sv
package pgng_pkg;

    localparam logic [30:0] TWO_LN2_Q30   = 31'd1488522236;
    localparam logic [14:0] SIGMA_RESET   = 15'd5284;
    localparam logic [14:0] CLIP_RESET    = 15'd15852;
    localparam logic [15:0] COUNT_RESET   = 16'd128;

    localparam logic [1:0]  CFG_SIGMA = 2'd0;
    localparam logic [1:0]  CFG_CLIP  = 2'd1;
    localparam logic [1:0]  CFG_COUNT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQA,
        ST_SQB,
        ST_CHECK,
        ST_LOG,
        ST_DIV,
        ST_SHA,
        ST_EMA,
        ST_SHB,
        ST_EMB
    } state_t;

    typedef enum logic [2:0] {
        LG_IDLE,
        LG_NORM,
        LG_SQR,
        LG_MUL,
        LG_RND
    } log_phase_t;

    typedef enum logic [1:0] {
        DS_IDLE,
        DS_DIV,
        DS_SQRT
    } ds_phase_t;

    typedef enum logic [1:0] {
        SH_IDLE,
        SH_MUL1,
        SH_MUL2,
        SH_RND
    } sh_phase_t;

endpackage

### rtl/core/polar_gaussian_noise_generator_top.sv
// Gaussian noise from pairs of Q1.15 uniform samples by the polar method. One pair
// is worked at a time: s is formed in the SQA and SQB states, a pair with s zero or
// at least one is dropped in the CHECK state, and an accepted pair passes through
// the serial normalize and 24-step squaring log unit, the bit-serial divider and
// square root, then two short scale/clip passes. A pair gives z0 then z1 in Q3.12
// on the master side; tlast marks the end of a batch of sample_count samples (z1 is
// dropped when z0 closes the batch) and tuser marks the last sample of a pair. A
// finished sample waits in the output register while the next pair is taken.
module polar_gaussian_noise_generator_top import pgng_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // uniform_a [15:0], uniform_b [31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // noise_sample [15:0]
    output logic        m_tlast,   // batch_end
    output logic [0:0]  m_tuser,   // pair_end [0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    state_t      state_reg, state_next;
    logic [15:0] ua_reg, ub_reg;
    logic [31:0] m_reg, m_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [14:0] sigma_reg, clip_reg;
    logic [15:0] count_reg;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [15:0] m_tdata_reg;
    logic        m_tlast_reg;
    logic        m_tuser_reg;

    logic        in_xfer, out_free, m_ok;
    logic        log_start, ds_start, sh_start, out_load, pair_last;
    logic [15:0] sq_in, sh_u;
    logic signed [31:0] sq;
    logic [15:0] cnt_inc, lim;
    logic        cnt_end;
    logic        log_done, ds_done, sh_done;
    logic [29:0] lval;
    logic [31:0] factor;
    logic [15:0] z;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_ok     = (m_reg != 32'd0) && (m_reg[31:30] == 2'b00);
    assign sq_in    = (state_reg == ST_SQA) ? ua_reg : ub_reg;
    assign sq       = $signed(sq_in) * $signed(sq_in);
    assign cnt_inc  = cnt_reg + 16'd1;
    assign lim      = (count_reg == 16'd0) ? 16'd1 : count_reg;
    assign cnt_end  = (cnt_inc >= lim) || (cnt_inc == 16'd0);
    assign sh_u     = (state_reg == ST_DIV) ? ua_reg : ub_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_xfer) state_next = ST_SQA;
            ST_SQA:   state_next = ST_SQB;
            ST_SQB:   state_next = ST_CHECK;
            ST_CHECK: state_next = m_ok ? ST_LOG : ST_IDLE;
            ST_LOG:   if (log_done) state_next = ST_DIV;
            ST_DIV:   if (ds_done) state_next = ST_SHA;
            ST_SHA:   if (sh_done) state_next = ST_EMA;
            ST_EMA:   if (out_free) state_next = cnt_end ? ST_IDLE : ST_SHB;
            ST_SHB:   if (sh_done) state_next = ST_EMB;
            ST_EMB:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        log_start = 1'b0;
        ds_start  = 1'b0;
        sh_start  = 1'b0;
        out_load  = 1'b0;
        pair_last = 1'b0;
        case (state_reg)
            ST_IDLE:  s_tready  = 1'b1;
            ST_CHECK: log_start = m_ok;
            ST_LOG:   ds_start  = log_done;
            ST_DIV:   sh_start  = ds_done;
            ST_EMA: begin
                out_load  = out_free;
                sh_start  = out_free && !cnt_end;
                pair_last = cnt_end;
            end
            ST_EMB: begin
                out_load  = out_free;
                pair_last = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        m_next = m_reg;
        case (state_reg)
            ST_SQA:  m_next = sq;
            ST_SQB:  m_next = m_reg + sq;
            default: ;
        endcase
        cnt_next      = out_load ? (cnt_end ? 16'd0 : cnt_inc) : cnt_reg;
        m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    pgng_log2 u_log (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (log_start),
        .m       (m_reg[29:0]),
        .done    (log_done),
        .lval    (lval)
    );

    pgng_divsqrt u_divsqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ds_start),
        .lval    (lval),
        .m       (m_reg[29:0]),
        .done    (ds_done),
        .factor  (factor)
    );

    pgng_shape u_shape (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sh_start),
        .u       (sh_u),
        .factor  (factor),
        .sigma   (sigma_reg),
        .clip    (clip_reg),
        .done    (sh_done),
        .z       (z)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= 16'd0;
            m_tvalid_reg <= 1'b0;
            sigma_reg    <= SIGMA_RESET;
            clip_reg     <= CLIP_RESET;
            count_reg    <= COUNT_RESET;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_SIGMA: sigma_reg <= cfg_data[14:0];
                    CFG_CLIP:  clip_reg  <= cfg_data[14:0];
                    CFG_COUNT: count_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_reg <= m_next;
        if (in_xfer) begin
            ua_reg <= s_tdata[15:0];
            ub_reg <= s_tdata[31:16];
        end
        if (out_load) begin
            m_tdata_reg <= z;
            m_tlast_reg <= cnt_end;
            m_tuser_reg <= pair_last;
        end
    end

    assign cfg_ready  = 1'b1;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tlast    = m_tlast_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

### rtl/core/pgng_log2.sv
module pgng_log2 import pgng_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [29:0] m,
    output logic        done,
    output logic [29:0] lval
);

    log_phase_t  phase_reg, phase_next;
    logic [30:0] y_reg, y_next;
    logic [4:0]  sh_reg, sh_next;
    logic [23:0] frac_reg, frac_next;
    logic [4:0]  it_reg, it_next;
    logic [59:0] prod_reg, prod_next;
    logic [29:0] lval_reg, lval_next;
    logic        done_reg, done_next;

    logic [61:0] sq;
    logic [31:0] t;
    logic [28:0] nl;
    logic [60:0] rnd;

    assign sq  = 62'(y_reg) * 62'(y_reg);
    assign t   = sq[61:30];
    assign nl  = {sh_reg, 24'd0} - {5'd0, frac_reg};
    assign rnd = {1'b0, prod_reg} + 61'h2000_0000;

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            LG_IDLE: if (start) phase_next = LG_NORM;
            LG_NORM: if (y_reg[30]) phase_next = LG_SQR;
            LG_SQR:  if (it_reg == 5'd23) phase_next = LG_MUL;
            LG_MUL:  phase_next = LG_RND;
            LG_RND:  phase_next = LG_IDLE;
            default: phase_next = LG_IDLE;
        endcase
    end

    always_comb begin
        y_next    = y_reg;
        sh_next   = sh_reg;
        frac_next = frac_reg;
        it_next   = it_reg;
        prod_next = prod_reg;
        lval_next = lval_reg;
        done_next = 1'b0;
        case (phase_reg)
            LG_IDLE: begin
                if (start) begin
                    y_next    = {1'b0, m};
                    sh_next   = 5'd0;
                    frac_next = 24'd0;
                    it_next   = 5'd0;
                end
            end
            LG_NORM: begin
                if (!y_reg[30]) begin
                    y_next  = {y_reg[29:0], 1'b0};
                    sh_next = sh_reg + 5'd1;
                end
            end
            LG_SQR: begin
                y_next    = t[31] ? t[31:1] : t[30:0];
                frac_next = {frac_reg[22:0], t[31]};
                it_next   = it_reg + 5'd1;
            end
            LG_MUL: prod_next = 60'(nl) * 60'(TWO_LN2_Q30);
            LG_RND: begin
                lval_next = rnd[59:30];
                done_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= LG_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        y_reg    <= y_next;
        sh_reg   <= sh_next;
        frac_reg <= frac_next;
        it_reg   <= it_next;
        prod_reg <= prod_next;
        lval_reg <= lval_next;
    end

    assign done = done_reg;
    assign lval = lval_reg;

endmodule

### rtl/core/pgng_divsqrt.sv
module pgng_divsqrt import pgng_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [29:0] lval,
    input  logic [29:0] m,
    output logic        done,
    output logic [31:0] factor
);

    ds_phase_t   phase_reg, phase_next;
    logic [5:0]  step_reg, step_next;
    logic [63:0] q_reg, q_next;
    logic [33:0] acc_reg, acc_next;
    logic [29:0] div_reg, div_next;
    logic [31:0] root_reg, root_next;
    logic        done_reg, done_next;

    logic [30:0] dr, dsub;
    logic        dge;
    logic [35:0] sr, trial, ssub;
    logic        sge;

    assign dr    = {acc_reg[29:0], q_reg[63]};
    assign dge   = dr >= {1'b0, div_reg};
    assign dsub  = dr - {1'b0, div_reg};
    assign sr    = {acc_reg, q_reg[63:62]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign sge   = sr >= trial;
    assign ssub  = sr - trial;

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            DS_IDLE: if (start) phase_next = DS_DIV;
            DS_DIV:  if (step_reg == 6'd63) phase_next = DS_SQRT;
            DS_SQRT: if (step_reg == 6'd31) phase_next = DS_IDLE;
            default: phase_next = DS_IDLE;
        endcase
    end

    always_comb begin
        step_next = step_reg;
        q_next    = q_reg;
        acc_next  = acc_reg;
        div_next  = div_reg;
        root_next = root_reg;
        done_next = 1'b0;
        case (phase_reg)
            DS_IDLE: begin
                if (start) begin
                    q_next    = {lval, 34'd0};
                    acc_next  = 34'd0;
                    div_next  = m;
                    step_next = 6'd0;
                end
            end
            DS_DIV: begin
                q_next    = {q_reg[62:0], dge};
                acc_next  = {4'd0, dge ? dsub[29:0] : dr[29:0]};
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd63) begin
                    acc_next  = 34'd0;
                    root_next = 32'd0;
                end
            end
            DS_SQRT: begin
                q_next    = {q_reg[61:0], 2'b00};
                acc_next  = sge ? ssub[33:0] : sr[33:0];
                root_next = {root_reg[30:0], sge};
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd31) begin
                    step_next = 6'd0;
                    done_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= DS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        q_reg    <= q_next;
        acc_reg  <= acc_next;
        div_reg  <= div_next;
        root_reg <= root_next;
    end

    assign done   = done_reg;
    assign factor = root_reg;

endmodule

### rtl/core/pgng_shape.sv
module pgng_shape import pgng_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [15:0] u,
    input  logic [31:0] factor,
    input  logic [14:0] sigma,
    input  logic [14:0] clip,
    output logic        done,
    output logic [15:0] z
);

    sh_phase_t   phase_reg, phase_next;
    logic [15:0] mag_reg, mag_next;
    logic        neg_reg, neg_next;
    logic [47:0] p1_reg, p1_next;
    logic [62:0] p2_reg, p2_next;
    logic [15:0] z_reg, z_next;
    logic        done_reg, done_next;

    logic [63:0] rs;
    logic [34:0] zr;
    logic [14:0] zc;

    assign rs = {1'b0, p2_reg} + 64'h1000_0000;
    assign zr = rs[63:29];
    assign zc = (zr > 35'(clip)) ? clip : zr[14:0];

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            SH_IDLE: if (start) phase_next = SH_MUL1;
            SH_MUL1: phase_next = SH_MUL2;
            SH_MUL2: phase_next = SH_RND;
            SH_RND:  phase_next = SH_IDLE;
            default: phase_next = SH_IDLE;
        endcase
    end

    always_comb begin
        mag_next  = mag_reg;
        neg_next  = neg_reg;
        p1_next   = p1_reg;
        p2_next   = p2_reg;
        z_next    = z_reg;
        done_next = 1'b0;
        case (phase_reg)
            SH_IDLE: begin
                if (start) begin
                    mag_next = u[15] ? (~u + 16'd1) : u;
                    neg_next = u[15];
                end
            end
            SH_MUL1: p1_next = 48'(mag_reg) * 48'(factor);
            SH_MUL2: p2_next = 63'(p1_reg) * 63'(sigma);
            SH_RND: begin
                z_next    = neg_reg ? (~{1'b0, zc} + 16'd1) : {1'b0, zc};
                done_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= SH_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        p1_reg  <= p1_next;
        p2_reg  <= p2_next;
        z_reg   <= z_next;
    end

    assign done = done_reg;
    assign z    = z_reg;

endmodule

### rtl/core/pgng_checker.sv
module pgng_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast,
    input logic [0:0]  m_tuser
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_batch_ends_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("batch end without pair end");

    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a pair is in work");

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output valid dropped before transfer");

    a_data_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

endmodule

bind polar_gaussian_noise_generator_top pgng_checker u_pgng_checker (.*);

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import pgng_pkg::*;

    typedef struct packed {
        logic [15:0] sample;
        logic        batch_end;
        logic        pair_end;
    } noise_t;

    typedef struct {
        logic [15:0] ua;
        logic [15:0] ub;
        logic        has_fixed;
        logic [15:0] fixed_sample;
    } row_t;

    localparam int LIMIT_CYCLES = 2_000_000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [31:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic m_tlast;
    logic [0:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    polar_gaussian_noise_generator_top dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    logic [14:0] sigma_q;
    logic [14:0] clip_q;
    logic [15:0] count_q;
    logic [15:0] in_batch;
    noise_t expected_noise[$];
    int errors = 0;
    int cycles = 0;
    int stall_pct = 38;

    function automatic logic [63:0] sqrt_floor(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w >>= 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v -= res + bit_w;
                res = (res >> 1) + bit_w;
            end else begin
                res >>= 1;
            end
            bit_w >>= 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] neglog2(logic [31:0] m);
        int k;
        logic [63:0] y;
        logic [63:0] frac;
        k = 0;
        frac = 0;
        while (k < 31 && (m >> (k + 1)) != 0) k++;
        y = 64'(m) << (30 - k);
        for (int i = 0; i < 24; i++) begin
            y = (y * y) >> 30;
            frac <<= 1;
            if (y >= (64'd1 << 31)) begin
                y >>= 1;
                frac |= 1;
            end
        end
        return (64'(30 - k) << 24) - frac;
    endfunction

    function automatic logic [15:0] scale_clip(logic signed [15:0] u, logic [63:0] factor);
        logic [63:0] mag;
        logic [63:0] z;
        mag = u < 0 ? 64'(-32'(u)) : 64'(u);
        z = (mag * factor * 64'(sigma_q) + (64'd1 << 28)) >> 29;
        if (z > clip_q) z = clip_q;
        if (u < 0) z = -z;
        return z[15:0];
    endfunction

    function automatic logic batch_step();
        logic [15:0] lim;
        lim = count_q == 0 ? 16'd1 : count_q;
        in_batch = in_batch + 16'd1;
        if (in_batch >= lim || in_batch == 0) begin
            in_batch = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // returns the number of samples produced
    function automatic int predict_pair(logic signed [15:0] a, logic signed [15:0] b);
        logic [31:0] m;
        logic [63:0] lq;
        logic [63:0] q;
        logic [63:0] factor;
        noise_t n;
        m = 32'(32'(a) * 32'(a)) + 32'(32'(b) * 32'(b));
        if (m == 0 || m >= (32'd1 << 30)) return 0;
        lq = (neglog2(m) * 64'(TWO_LN2_Q30) + (64'd1 << 29)) >> 30;
        q = (lq << 34) / 64'(m);
        factor = sqrt_floor(q);
        n.sample = scale_clip(a, factor);
        if (batch_step()) begin
            n.batch_end = 1'b1;
            n.pair_end = 1'b1;
            expected_noise.push_back(n);
            return 1;
        end
        n.batch_end = 1'b0;
        n.pair_end = 1'b0;
        expected_noise.push_back(n);
        n.sample = scale_clip(b, factor);
        n.batch_end = batch_step();
        n.pair_end = 1'b1;
        expected_noise.push_back(n);
        return 2;
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stall, check on each transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_noise.size() == 0) begin
                    errors <= errors + 1;
                    if (errors < 10) $display("unexpected transfer: %h", m_tdata);
                end else begin
                    noise_t e;
                    e = expected_noise.pop_front();
                    if (e.sample !== m_tdata || e.batch_end !== m_tlast
                            || e.pair_end !== m_tuser[0]) begin
                        errors <= errors + 1;
                        if (errors < 10)
                            $display("mismatch: exp %h/%b/%b got %h/%b/%b", e.sample,
                                     e.batch_end, e.pair_end, m_tdata, m_tlast, m_tuser);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SIGMA: sigma_q = val[14:0];
            CFG_CLIP:  clip_q = val[14:0];
            CFG_COUNT: count_q = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (expected_noise.size() != 0) @(posedge aclk);
        repeat (250) @(posedge aclk);
    endtask

    task automatic send_pair(logic [15:0] a, logic [15:0] b);
        while ($urandom_range(99) < stall_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata <= {b, a};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        void'(predict_pair(a, b));
    endtask

    task automatic send_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_pairs(int n);
        logic [15:0] a;
        logic [15:0] b;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) < 8) begin
                // mostly inside the unit circle
                a = 16'($signed($urandom_range(46340)) - 23170);
                b = 16'($signed($urandom_range(46340)) - 23170);
                if ($urandom_range(9) == 0) a = 16'($urandom_range(7)) - 16'd3;
            end else begin
                a = 16'($urandom);
                b = 16'($urandom);
            end
            send_pair(a, b);
        end
        send_idle();
    endtask

    row_t table_rows[$];

    initial begin
        sigma_q = SIGMA_RESET;
        clip_q = CLIP_RESET;
        count_q = COUNT_RESET;
        in_batch = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows: extremes, rejects, clipping
        table_rows = '{
            '{16'h0000, 16'h0000, 1'b0, 16'h0},     // s zero, rejected
            '{16'h8000, 16'h0000, 1'b0, 16'h0},     // s one, rejected
            '{16'h7FFF, 16'h7FFF, 1'b0, 16'h0},     // rejected
            '{16'h8000, 16'h8000, 1'b0, 16'h0},
            '{16'h0001, 16'h0000, 1'b1, 16'h3DEC},  // tiny s, clip positive
            '{16'hFFFF, 16'h0000, 1'b1, 16'hC214},  // tiny s, clip negative
            '{16'h0000, 16'h0001, 1'b0, 16'h0},
            '{16'h7FFF, 16'h0000, 1'b0, 16'h0},     // s just below one
            '{16'h0000, 16'h8001, 1'b0, 16'h0},
            '{16'h4000, 16'hC000, 1'b0, 16'h0},
            '{16'h5A82, 16'h5A82, 1'b0, 16'h0},
            '{16'h1234, 16'hEDCC, 1'b0, 16'h0},
            '{16'h5555, 16'hAAAA, 1'b0, 16'h0}
        };
        foreach (table_rows[i]) begin
            noise_t fx;
            send_pair(table_rows[i].ua, table_rows[i].ub);
            // typed value replaces the predicted first sample of the pair
            if (table_rows[i].has_fixed) begin
                fx = expected_noise[expected_noise.size() - 2];
                fx.sample = table_rows[i].fixed_sample;
                expected_noise[expected_noise.size() - 2] = fx;
            end
        end
        send_idle();
        drain();

        // sigma zero gives zero samples
        write_reg(CFG_SIGMA, 16'h0000);
        write_reg(CFG_COUNT, 16'd0);
        send_pair(16'h1000, 16'hF000);
        send_pair(16'h7FFF, 16'h0000);
        send_idle();
        drain();

        // max sigma, clip zero; odd batch
        write_reg(CFG_SIGMA, 16'h7FFF);
        write_reg(CFG_CLIP, 16'h0000);
        write_reg(CFG_COUNT, 16'd3);
        send_pair(16'h2000, 16'h2000);
        send_pair(16'hE000, 16'h1000);
        send_idle();
        drain();

        write_reg(CFG_CLIP, 16'hFFFF);
        write_reg(CFG_COUNT, 16'd1);
        random_pairs(200);
        drain();

        // counter above limit after lowering
        write_reg(CFG_SIGMA, 16'd4096);
        write_reg(CFG_COUNT, 16'd40);
        random_pairs(30);
        drain();
        write_reg(CFG_COUNT, 16'd5);
        write_reg(CFG_CLIP, 16'd8000);
        random_pairs(400);
        drain();

        write_reg(CFG_COUNT, 16'hFFFF);
        write_reg(CFG_SIGMA, 16'd5284);
        write_reg(CFG_CLIP, 16'd15852);
        stall_pct = 0;
        random_pairs(300);
        drain();
        stall_pct = 38;

        write_reg(CFG_COUNT, 16'd2);
        random_pairs(400);
        drain();
        write_reg(CFG_COUNT, 16'd128);
        write_reg(CFG_SIGMA, 16'd20000);
        random_pairs(450);
        drain();

        if (errors == 0 && expected_noise.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

### polar_gaussian_noise_generator_top.f
rtl/core/pgng_pkg.sv
rtl/core/pgng_log2.sv
rtl/core/pgng_divsqrt.sv
rtl/core/pgng_shape.sv
rtl/core/polar_gaussian_noise_generator_top.sv
rtl/core/pgng_checker.sv
sim/testbench.sv
